### hw/rtl/etc2_rgb_block_decoder_top_macros.svh
// assertion macros for the etc2 block decoder
`ifndef ETC2_RGB_BLOCK_DECODER_TOP_MACROS_SVH
`define ETC2_RGB_BLOCK_DECODER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define E2_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define E2_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define E2_ASSERT(label, clk, rst, prop, msg)
`define E2_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

### hw/rtl/etc2_pkg.sv
// shared types, tables and helpers for the etc2 block decoder
`default_nettype none
package etc2_pkg;
  localparam int unsigned QueueDepthDefault = 2;

  typedef enum logic [1:0] {
    MODE_ETC1 = 2'd0,
    MODE_T    = 2'd1,
    MODE_H    = 2'd2,
    MODE_PLANAR = 2'd3
  } mode_t;

  // classified block handed from front to back
  typedef struct packed {
    mode_t       mode;
    logic [63:0] bits;
  } blk_t;

  function automatic logic [6:0] dist_lut(input logic [2:0] i);
    logic [6:0] d;
    unique case (i)
      3'd0: d = 7'd3;
      3'd1: d = 7'd6;
      3'd2: d = 7'd11;
      3'd3: d = 7'd16;
      3'd4: d = 7'd23;
      3'd5: d = 7'd32;
      3'd6: d = 7'd41;
      default: d = 7'd64;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] mod_lut(input logic [2:0] cw, input logic big);
    logic [7:0] m;
    unique case (cw)
      3'd0: m = big ? 8'd8 : 8'd2;
      3'd1: m = big ? 8'd17 : 8'd5;
      3'd2: m = big ? 8'd29 : 8'd9;
      3'd3: m = big ? 8'd42 : 8'd13;
      3'd4: m = big ? 8'd60 : 8'd18;
      3'd5: m = big ? 8'd80 : 8'd24;
      3'd6: m = big ? 8'd106 : 8'd33;
      default: m = big ? 8'd183 : 8'd47;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] sat8(input logic signed [11:0] v);
    logic [7:0] r;
    if (v < 0) r = 8'd0;
    else if (v > 12'sd255) r = 8'd255;
    else r = v[7:0];
    return r;
  endfunction
endpackage
`default_nettype wire

### hw/rtl/etc2_front.sv
// front end: accepts blocks and works out the coding mode
`default_nettype none
module etc2_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         valid,
  output      logic         stall,
  input  wire logic [63:0]  block_bits,
  output      logic         q_valid,
  input  wire logic         q_stall,
  output      etc2_pkg::blk_t q_data
);
  import etc2_pkg::*;

  logic       diff;
  logic [5:0] sr, sg, sb;
  mode_t      mode;

  // 5-bit base plus signed 3-bit delta; overflow or underflow shows in bit 5
  assign sr = {1'b0, block_bits[63:59]} + {{3{block_bits[58]}}, block_bits[58:56]};
  assign sg = {1'b0, block_bits[55:51]} + {{3{block_bits[50]}}, block_bits[50:48]};
  assign sb = {1'b0, block_bits[47:43]} + {{3{block_bits[42]}}, block_bits[42:40]};
  assign diff = block_bits[33];

  always_comb begin
    priority if (!diff) mode = MODE_ETC1;
    else if (sr[5]) mode = MODE_T;
    else if (sg[5]) mode = MODE_H;
    else if (sb[5]) mode = MODE_PLANAR;
    else mode = MODE_ETC1;
  end

  assign stall = q_valid && q_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!stall) begin
      q_valid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall && valid) begin
      q_data.mode <= mode;
      q_data.bits <= block_bits;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/etc2_queue.sv
// short fifo between front and back
`default_nettype none
module etc2_queue #(
  parameter int unsigned Depth = etc2_pkg::QueueDepthDefault
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output      logic           in_stall,
  input  wire etc2_pkg::blk_t in_data,
  output      logic           out_valid,
  input  wire logic           out_stall,
  output      etc2_pkg::blk_t out_data
);
  import etc2_pkg::*;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  blk_t         mem [Depth];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;
  logic          push, pop;

  assign in_stall  = (cnt == (AW+1)'(Depth));
  assign out_valid = (cnt != '0);
  assign push = in_valid && !in_stall;
  assign pop  = out_valid && !out_stall;
  assign out_data = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= (wp == AW'(Depth-1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == AW'(Depth-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_data;
  end

  `include "etc2_rgb_block_decoder_top_macros.svh"
  `E2_ASSERT(a_cnt_bound, clk, rst, cnt <= (AW+1)'(Depth), "queue count overflow")
  `E2_ASSERT(a_no_pop_empty, clk, rst, (cnt == '0) |-> !pop, "pop from empty queue")
  `E2_ASSERT(a_cnt_step, clk, rst, (push && !pop) |=> (cnt == $past(cnt) + 1'b1), "bad count step")
endmodule
`default_nettype wire

### hw/rtl/etc2_back.sv
// back end: decodes one pixel a beat from a classified block
`default_nettype none
module etc2_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  output      logic           q_stall,
  input  wire etc2_pkg::blk_t q_data,
  output      logic           valid,
  input  wire logic           stall,
  output      logic [3:0]     pixel_index,
  output      logic [7:0]     red,
  output      logic [7:0]     green,
  output      logic [7:0]     blue,
  output      logic           last_pixel
);
  import etc2_pkg::*;

  logic [3:0]  pix;
  logic [7:0]  b0, b1, b2, b3;
  logic [15:0] msb, lsb;
  logic [1:0]  x, y;
  logic [3:0]  bi;
  logic        mb, lb;
  logic [7:0]  c0 [3], c1 [3], base [3];
  logic signed [11:0] delta;
  logic [7:0]  r_n, g_n, b_n;
  logic        adv, out_free;

  assign b0 = q_data.bits[63:56];
  assign b1 = q_data.bits[55:48];
  assign b2 = q_data.bits[47:40];
  assign b3 = q_data.bits[39:32];
  assign msb = q_data.bits[31:16];
  assign lsb = q_data.bits[15:0];
  assign x = pix[1:0];
  assign y = pix[3:2];
  // index planes run column-major
  assign bi = {x, y};
  assign mb = msb[bi];
  assign lb = lsb[bi];

  // planar helpers
  function automatic logic [7:0] planar(input logic [7:0] o, input logic [7:0] h,
                                        input logic [7:0] v, input logic [1:0] px,
                                        input logic [1:0] py);
    logic signed [12:0] s;
    s = 13'($signed({1'b0, px}) * ($signed({5'b0, h}) - $signed({5'b0, o})))
      + 13'($signed({1'b0, py}) * ($signed({5'b0, v}) - $signed({5'b0, o})))
      + $signed({3'b0, o, 2'b0}) + 13'sd2;
    return sat8(12'(s >>> 2));
  endfunction

  always_comb begin
    logic [4:0] r5, g5, bb5, r5b, g5b, bb5b;
    logic [3:0] tr1, hr1, hg1, hb1, hr2, hg2, hb2;
    logic [2:0] di, cw;
    logic [6:0] d;
    logic [7:0] m;
    logic [5:0] ro, bo, rh, bh, rv, bv;
    logic [6:0] go, gh, gv;
    logic [7:0] o [3], h [3], v [3];
    logic       sub, half;
    r5 = b0[7:3]; g5 = b1[7:3]; bb5 = b2[7:3];
    r5b = r5 + {{2{b0[2]}}, b0[2:0]};
    g5b = g5 + {{2{b1[2]}}, b1[2:0]};
    bb5b = bb5 + {{2{b2[2]}}, b2[2:0]};
    tr1 = {b0[4:3], b0[1:0]};
    hr1 = b0[6:3]; hg1 = {b0[2:0], b1[4]}; hb1 = {b1[3], b1[1:0], b2[7]};
    hr2 = b2[6:3]; hg2 = {b2[2:0], b3[7]}; hb2 = b3[6:3];
    ro = b0[6:1]; go = {b0[0], b1[6:1]}; bo = {b1[0], b2[4:3], b2[1:0], b3[7]};
    rh = {b3[6:2], b3[0]}; gh = msb[15:9]; bh = {msb[8], msb[7:3]};
    rv = {msb[2:0], lsb[15:13]}; gv = {lsb[12:8], lsb[7:6]}; bv = lsb[5:0];
    o[0] = {ro, ro[5:4]}; o[1] = {go, go[6]}; o[2] = {bo, bo[5:4]};
    h[0] = {rh, rh[5:4]}; h[1] = {gh, gh[6]}; h[2] = {bh, bh[5:4]};
    v[0] = {rv, rv[5:4]}; v[1] = {gv, gv[6]}; v[2] = {bv, bv[5:4]};
    di = '0; d = '0; m = '0; sub = 1'b0; half = 1'b0; cw = '0;
    for (int k = 0; k < 3; k++) begin
      c0[k] = '0; c1[k] = '0;
    end
    delta = '0;
    unique case (q_data.mode)
      MODE_T: begin
        di = {b3[3:2], b3[0]};
        d = dist_lut(di);
        c0[0] = {tr1, tr1}; c0[1] = {b1[7:4], b1[7:4]}; c0[2] = {b1[3:0], b1[3:0]};
        c1[0] = {b2[7:4], b2[7:4]}; c1[1] = {b2[3:0], b2[3:0]};
        c1[2] = {b3[7:4], b3[7:4]};
        half = (mb || lb);
        unique case ({mb, lb})
          2'b00: delta = '0;
          2'b01: delta = 12'(d);
          2'b10: delta = '0;
          default: delta = -12'(d);
        endcase
      end
      MODE_H: begin
        di = {b3[2], b3[0], ({hr1, hg1, hb1} >= {hr2, hg2, hb2})};
        d = dist_lut(di);
        c0[0] = {hr1, hr1}; c0[1] = {hg1, hg1}; c0[2] = {hb1, hb1};
        c1[0] = {hr2, hr2}; c1[1] = {hg2, hg2}; c1[2] = {hb2, hb2};
        half = mb;
        delta = lb ? -12'(d) : 12'(d);
      end
      MODE_PLANAR: begin
        half = 1'b0;
      end
      default: begin
        if (b3[1]) begin
          c0[0] = {r5, r5[4:2]}; c0[1] = {g5, g5[4:2]}; c0[2] = {bb5, bb5[4:2]};
          c1[0] = {r5b, r5b[4:2]}; c1[1] = {g5b, g5b[4:2]}; c1[2] = {bb5b, bb5b[4:2]};
        end else begin
          c0[0] = {b0[7:4], b0[7:4]}; c1[0] = {b0[3:0], b0[3:0]};
          c0[1] = {b1[7:4], b1[7:4]}; c1[1] = {b1[3:0], b1[3:0]};
          c0[2] = {b2[7:4], b2[7:4]}; c1[2] = {b2[3:0], b2[3:0]};
        end
        // flip bit picks split direction
        half = b3[0] ? bi[1] : bi[3];
        cw = half ? b3[4:2] : b3[7:5];
        m = mod_lut(cw, lb);
        sub = mb;
        delta = sub ? -12'(m) : 12'(m);
      end
    endcase
    for (int k = 0; k < 3; k++) base[k] = half ? c1[k] : c0[k];
    if (q_data.mode == MODE_PLANAR) begin
      r_n = planar(o[0], h[0], v[0], x, y);
      g_n = planar(o[1], h[1], v[1], x, y);
      b_n = planar(o[2], h[2], v[2], x, y);
    end else begin
      r_n = sat8(12'(base[0]) + delta);
      g_n = sat8(12'(base[1]) + delta);
      b_n = sat8(12'(base[2]) + delta);
    end
  end

  assign out_free = !valid || !stall;
  assign adv = q_valid && out_free;
  // release the queue entry with the last pixel
  assign q_stall = !(adv && pix == 4'd15);

  always_ff @(posedge clk) begin
    if (rst) begin
      pix <= '0;
      valid <= 1'b0;
    end else begin
      if (out_free) valid <= q_valid;
      if (adv) pix <= pix + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pixel_index <= pix;
      red <= r_n;
      green <= g_n;
      blue <= b_n;
      last_pixel <= (pix == 4'd15);
    end
  end

  `include "etc2_rgb_block_decoder_top_macros.svh"
  `E2_ASSERT(a_last_idx, clk, rst, valid |-> (last_pixel == (pixel_index == 4'd15)), "last flag mismatch")
  `E2_ASSERT(a_hold, clk, rst, (valid && stall) |=> (valid && $stable(pixel_index)), "beat dropped while stalled")
  `E2_ASSERT(a_seq, clk, rst, (valid && !stall && !last_pixel) |=> (!valid || pixel_index == $past(pixel_index) + 1'b1), "pixel order broken")
endmodule
`default_nettype wire

### hw/rtl/etc2_rgb_block_decoder_top.sv
// a block passes the front register, the queue and the back output register
// one pixel a cycle while out_stall is low (the back end's single pixel datapath)
// a two-entry queue lets the front take the next block while pixels stream out
// rst is synchronous, active high, and empties the front register, queue and output
`default_nettype none
module etc2_rgb_block_decoder_top #(
  parameter int unsigned QueueDepth = etc2_pkg::QueueDepthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [63:0] block_bits,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [3:0]  pixel_index,
  output      logic [7:0]  red,
  output      logic [7:0]  green,
  output      logic [7:0]  blue,
  output      logic        last_pixel
);
  import etc2_pkg::*;

  logic f_valid, f_stall, b_valid, b_stall;
  blk_t f_data, b_data;

  etc2_front u_front (
    .clk, .rst, .valid(in_valid), .stall(in_stall), .block_bits,
    .q_valid(f_valid), .q_stall(f_stall), .q_data(f_data)
  );

  etc2_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst, .in_valid(f_valid), .in_stall(f_stall), .in_data(f_data),
    .out_valid(b_valid), .out_stall(b_stall), .out_data(b_data)
  );

  etc2_back u_back (
    .clk, .rst, .q_valid(b_valid), .q_stall(b_stall), .q_data(b_data),
    .valid(out_valid), .stall(out_stall), .pixel_index, .red, .green, .blue,
    .last_pixel
  );
endmodule
`default_nettype wire
